/* sv/smp_pkg.sv */
package smp_pkg;

    // Commands carried by the input channel.
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_REG    = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    // Channel register selects.
    localparam logic [3:0] REG_CONTROL = 4'd0;
    localparam logic [3:0] REG_START   = 4'd1;
    localparam logic [3:0] REG_STEP    = 4'd2;
    localparam logic [3:0] REG_STEP_FR = 4'd3;
    localparam logic [3:0] REG_ST_OFF  = 4'd4;
    localparam logic [3:0] REG_LOOP    = 4'd5;
    localparam logic [3:0] REG_END     = 4'd6;
    localparam logic [3:0] REG_VOL_L   = 4'd7;
    localparam logic [3:0] REG_VOL_R   = 4'd8;

    // Control register bit positions.
    localparam int CTL_ACTIVE   = 0;
    localparam int CTL_UNSIGNED = 1;
    localparam int CTL_STEREO   = 2;

    // Loop modes, control bits 4:3.
    localparam logic [1:0] LOOP_NONE  = 2'd0;
    localparam logic [1:0] LOOP_FWD   = 2'd1;
    localparam logic [1:0] LOOP_BIDIR = 2'd2;

    localparam int ACTIVE_RESET = 8;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic [4:0]  ctl;
        logic        playing;
        logic        backward;
        logic [15:0] addr;
        logic [15:0] frac;
        logic [15:0] step_whole;
        logic [15:0] step_frac;
        logic [15:0] st_off;
        logic [15:0] loop_start;
        logic [15:0] end_addr;
        logic [5:0]  vol_l;
        logic [5:0]  vol_r;
        logic [7:0]  prev_l;
        logic [7:0]  prev_r;
    } t_chan;

endpackage

/* sv/smp_cell.sv */
module smp_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  smp_pkg::t_chan i_next,
    input  logic           i_wr,
    input  logic [3:0]     i_sel,
    input  logic [15:0]    i_data,
    output smp_pkg::t_chan o_state
);

    smp_pkg::t_chan r_state;
    smp_pkg::t_chan n_state;

    always_comb begin
        n_state = r_state;
        if (i_shift) begin
            n_state = i_next;
        end else if (i_wr) begin
            case (i_sel)
                smp_pkg::REG_CONTROL: n_state.ctl = i_data[4:0];
                smp_pkg::REG_START: begin
                    n_state.addr     = i_data;
                    n_state.frac     = '0;
                    n_state.prev_l   = '0;
                    n_state.prev_r   = '0;
                    n_state.playing  = 1'b1;
                    n_state.backward = 1'b0;
                end
                smp_pkg::REG_STEP:    n_state.step_whole = i_data;
                smp_pkg::REG_STEP_FR: n_state.step_frac  = i_data;
                smp_pkg::REG_ST_OFF:  n_state.st_off     = i_data;
                smp_pkg::REG_LOOP:    n_state.loop_start = i_data;
                smp_pkg::REG_END:     n_state.end_addr   = i_data;
                smp_pkg::REG_VOL_L:   n_state.vol_l      = i_data[5:0];
                smp_pkg::REG_VOL_R:   n_state.vol_r      = i_data[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

/* sv/smp_voice.sv */
module smp_voice #(
    parameter int ACC_W = 26
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_clear,
    input  logic                    i_en,
    input  smp_pkg::t_chan          i_chan,
    input  logic [7:0]              i_byte_l,
    input  logic [7:0]              i_byte_r,
    output smp_pkg::t_chan          o_chan,
    output logic signed [ACC_W-1:0] o_acc_l,
    output logic signed [ACC_W-1:0] o_acc_r
);

    logic [7:0]  smp_l;
    logic [7:0]  smp_r;
    logic [16:0] frac_sum;
    logic [16:0] fwd_addr;
    logic [16:0] back_limit;
    logic [1:0]  mode;

    // Stage 2: difference to previous sample and fraction.
    logic              r_p2_en;
    logic signed [8:0] r_p2_dl;
    logic signed [8:0] r_p2_dr;
    logic [7:0]        r_p2_pl;
    logic [7:0]        r_p2_pr;
    logic [7:0]        r_p2_f;
    logic [5:0]        r_p2_vl;
    logic [5:0]        r_p2_vr;
    // Stage 3: interpolated samples.
    logic               r_p3_en;
    logic signed [16:0] r_p3_sl;
    logic signed [16:0] r_p3_sr;
    logic [5:0]         r_p3_vl;
    logic [5:0]         r_p3_vr;
    // Stage 4: scaled samples.
    logic               r_p4_en;
    logic signed [21:0] r_p4_l;
    logic signed [21:0] r_p4_r;
    logic signed [ACC_W-1:0] r_acc_l;
    logic signed [ACC_W-1:0] r_acc_r;

    logic signed [17:0] mul_l;
    logic signed [17:0] mul_r;
    logic signed [17:0] int_l;
    logic signed [17:0] int_r;
    logic signed [23:0] scl_l;
    logic signed [23:0] scl_r;

    assign smp_l = i_byte_l ^ {i_chan.ctl[smp_pkg::CTL_UNSIGNED], 7'b0};
    assign smp_r = i_chan.ctl[smp_pkg::CTL_STEREO]
                 ? (i_byte_r ^ {i_chan.ctl[smp_pkg::CTL_UNSIGNED], 7'b0}) : smp_l;
    assign mode       = i_chan.ctl[4:3];
    assign frac_sum   = {1'b0, i_chan.frac} + {1'b0, i_chan.step_frac};
    assign fwd_addr   = {1'b0, i_chan.addr} + {1'b0, i_chan.step_whole};
    assign back_limit = {1'b0, i_chan.step_whole} + {1'b0, i_chan.loop_start};

    // Position update; on a fraction carry the current samples become the previous ones.
    always_comb begin
        o_chan = i_chan;
        if (i_en) begin
            o_chan.frac = frac_sum[15:0];
            if (frac_sum[16]) begin
                o_chan.prev_l = smp_l;
                o_chan.prev_r = smp_r;
                if (!i_chan.backward) begin
                    if (fwd_addr > {1'b0, i_chan.end_addr}) begin
                        case (mode)
                            smp_pkg::LOOP_FWD: o_chan.addr = i_chan.loop_start;
                            smp_pkg::LOOP_BIDIR: begin
                                o_chan.addr     = i_chan.end_addr;
                                o_chan.backward = 1'b1;
                            end
                            default: o_chan.playing = 1'b0;
                        endcase
                    end else begin
                        o_chan.addr = fwd_addr[15:0];
                    end
                end else begin
                    if ({1'b0, i_chan.addr} < back_limit) begin
                        o_chan.addr     = i_chan.loop_start;
                        o_chan.backward = 1'b0;
                    end else begin
                        o_chan.addr = i_chan.addr - i_chan.step_whole;
                    end
                end
            end
        end
    end

    // prev * (256 - f) + s * f, written as prev * 256 + (s - prev) * f.
    assign mul_l = r_p2_dl * $signed({1'b0, r_p2_f});
    assign mul_r = r_p2_dr * $signed({1'b0, r_p2_f});
    assign int_l = 18'($signed({r_p2_pl, 8'h00})) + mul_l;
    assign int_r = 18'($signed({r_p2_pr, 8'h00})) + mul_r;
    assign scl_l = r_p3_sl * $signed({1'b0, r_p3_vl});
    assign scl_r = r_p3_sr * $signed({1'b0, r_p3_vr});

    always_ff @(posedge i_clk) begin
        r_p2_dl <= $signed({smp_l[7], smp_l}) - $signed({i_chan.prev_l[7], i_chan.prev_l});
        r_p2_dr <= $signed({smp_r[7], smp_r}) - $signed({i_chan.prev_r[7], i_chan.prev_r});
        r_p2_pl <= i_chan.prev_l;
        r_p2_pr <= i_chan.prev_r;
        r_p2_f  <= i_chan.frac[15:8];
        r_p2_vl <= i_chan.vol_l;
        r_p2_vr <= i_chan.vol_r;
        r_p3_sl <= int_l[16:0];
        r_p3_sr <= int_r[16:0];
        r_p3_vl <= r_p2_vl;
        r_p3_vr <= r_p2_vr;
        r_p4_l  <= scl_l[21:0];
        r_p4_r  <= scl_r[21:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_en <= 1'b0;
            r_p3_en <= 1'b0;
            r_p4_en <= 1'b0;
            r_acc_l <= '0;
            r_acc_r <= '0;
        end else begin
            r_p2_en <= i_en;
            r_p3_en <= r_p2_en;
            r_p4_en <= r_p3_en;
            if (i_clear) begin
                r_acc_l <= '0;
                r_acc_r <= '0;
            end else if (r_p4_en) begin
                r_acc_l <= r_acc_l + ACC_W'(r_p4_l);
                r_acc_r <= r_acc_r + ACC_W'(r_p4_r);
            end
        end
    end

    assign o_acc_l = r_acc_l;
    assign o_acc_r = r_acc_r;

endmodule

/* sv/smp_mix.sv */
module smp_mix #(
    parameter int ACC_W = 26
) (
    input  logic                    i_clk,
    input  logic                    i_load,
    input  logic signed [ACC_W-1:0] i_acc,
    output logic [15:0]             o_level
);

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

    logic signed [ACC_W-1:0] shifted;
    logic [15:0]             sat;
    logic [15:0]             r_level;

    // Floor shift by 6, clamp to 16 bits, then flip the sign for offset binary.
    always_comb begin
        shifted = i_acc >>> 6;
        if (shifted > SAT_HI) begin
            sat = 16'h7FFF;
        end else if (shifted < SAT_LO) begin
            sat = 16'h8000;
        end else begin
            sat = shifted[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_level <= {~sat[15], sat[14:0]};
        end
    end

    assign o_level = r_level;

endmodule

/* sv/sample_playback_mixer.sv */
// Multi-channel 8-bit sample player with a stereo mixer.
// Input channel (i_valid / o_stall): one command per beat. A sample write
// stores one byte of sample memory, a register write sets one channel
// register. A tick mixes all active, playing channels below the channel
// count and delivers one beat of left and right levels on the output
// channel (o_valid / i_stall).
// Channel states sit in a ring of cells that rotates once per tick through
// the shared voice unit, one channel per cycle, in CHANNELS + 1 ring steps;
// the voice then runs a sample read, difference, interpolate, scale and
// accumulate pipeline, and the mixer saturates the sum. While a tick runs,
// every command is stalled. Writes and sample stores are accepted while a
// result waits; a new tick is stalled until the waiting result is taken.
// While i_stall is high the result holds. Reset clears all channel state
// and sets the channel count to 8; sample memory holds no defined value
// until written.
module sample_playback_mixer #(
    parameter int CHANNELS  = 16,
    parameter int ADDR_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [3:0]  i_channel,
    input  logic [3:0]  i_reg_select,
    input  logic [15:0] i_address,
    input  logic [15:0] i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_left_level,
    output logic [15:0] o_right_level
);

    localparam int ACC_W   = 22 + $clog2(CHANNELS);
    localparam int LAST    = CHANNELS + 4;
    localparam int CNT_W   = $clog2(LAST + 1);
    localparam int CMP_W   = (CNT_W > 5) ? CNT_W : 5;
    localparam int MEM_DEP = 1 << ADDR_BITS;

    smp_pkg::t_state r_state;
    smp_pkg::t_state n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [4:0]       r_active;
    logic             r_out_valid;

    logic             in_acc;
    logic             tick_acc;
    logic             reg_wr;
    logic             shift;
    logic             load_out;
    logic             head_en;

    smp_pkg::t_chan   ring [CHANNELS];
    smp_pkg::t_chan   tail;
    smp_pkg::t_chan   r_s1;
    logic             r_s1_en;

    logic [7:0]           mem [MEM_DEP];
    logic [7:0]           r_rd_l;
    logic [7:0]           r_rd_r;
    logic [ADDR_BITS-1:0] rd_addr_l;
    logic [ADDR_BITS-1:0] rd_addr_r;

    logic signed [ACC_W-1:0] acc_l;
    logic signed [ACC_W-1:0] acc_r;

    assign o_stall  = (r_state == smp_pkg::ST_RUN)
                    || (r_out_valid && i_command == smp_pkg::CMD_TICK);
    assign in_acc   = i_valid && !o_stall;
    assign tick_acc = in_acc && i_command == smp_pkg::CMD_TICK;
    assign reg_wr   = in_acc && i_command == smp_pkg::CMD_REG
                    && int'(i_channel) < CHANNELS;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            smp_pkg::ST_IDLE: if (tick_acc) n_state = smp_pkg::ST_RUN;
            smp_pkg::ST_RUN:  if (r_cnt == CNT_W'(LAST)) n_state = smp_pkg::ST_IDLE;
            default:          n_state = smp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        shift    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            smp_pkg::ST_IDLE: ;
            smp_pkg::ST_RUN: begin
                shift    = r_cnt <= CNT_W'(CHANNELS);
                load_out = r_cnt == CNT_W'(LAST);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smp_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_active    <= 5'(smp_pkg::ACTIVE_RESET);
            r_out_valid <= 1'b0;
            r_s1_en     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (tick_acc) begin
                r_cnt <= '0;
            end else if (r_state == smp_pkg::ST_RUN) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cfg_we) begin
                r_active <= i_cfg_data;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            r_s1_en <= shift && head_en;
        end
    end

    // The head cell is channel r_cnt while the ring turns; the empty slot comes last.
    assign head_en = CMP_W'(r_cnt) < CMP_W'(CHANNELS) && CMP_W'(r_cnt) < CMP_W'(r_active)
                   && ring[0].ctl[smp_pkg::CTL_ACTIVE] && ring[0].playing;

    assign rd_addr_l = ADDR_BITS'(ring[0].addr);
    assign rd_addr_r = ADDR_BITS'({1'b0, ring[0].addr} + {1'b0, ring[0].st_off});

    always_ff @(posedge i_clk) begin
        if (in_acc && i_command == smp_pkg::CMD_SAMPLE) begin
            mem[ADDR_BITS'(i_address)] <= i_data[7:0];
        end
        if (shift) begin
            r_rd_l <= mem[rd_addr_l];
            r_rd_r <= mem[rd_addr_r];
            r_s1   <= ring[0];
        end
    end

    for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
        smp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_next  ((i == CHANNELS - 1) ? tail : ring[(i + 1) % CHANNELS]),
            .i_wr    (reg_wr && int'(i_channel) == i),
            .i_sel   (i_reg_select),
            .i_data  (i_data),
            .o_state (ring[i])
        );
    end

    smp_voice #(.ACC_W(ACC_W)) u_voice (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (tick_acc),
        .i_en     (r_s1_en),
        .i_chan   (r_s1),
        .i_byte_l (r_rd_l),
        .i_byte_r (r_rd_r),
        .o_chan   (tail),
        .o_acc_l  (acc_l),
        .o_acc_r  (acc_r)
    );

    smp_mix #(.ACC_W(ACC_W)) u_mix_l (
        .i_clk   (i_clk),
        .i_load  (load_out),
        .i_acc   (acc_l),
        .o_level (o_left_level)
    );

    smp_mix #(.ACC_W(ACC_W)) u_mix_r (
        .i_clk   (i_clk),
        .i_load  (load_out),
        .i_acc   (acc_r),
        .o_level (o_right_level)
    );

    assign o_valid = r_out_valid;

endmodule

/* verif/tb.sv */
module tb;

    localparam int NCH = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES = NCH + 15;

    typedef struct {
        logic [15:0] left;
        logic [15:0] right;
    } t_levels;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [4:0]  i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_command;
    logic [3:0]  i_channel;
    logic [3:0]  i_reg_select;
    logic [15:0] i_address;
    logic [15:0] i_data;
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_left_level;
    logic [15:0] o_right_level;

    sample_playback_mixer u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_command(i_command), .i_channel(i_channel), .i_reg_select(i_reg_select),
        .i_address(i_address), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_left_level(o_left_level), .o_right_level(o_right_level)
    );

    // Mirror of the block's state.
    logic [7:0]  sample_mem [0:65535];
    logic [4:0]  mix_count;
    logic [4:0]  m_ctl      [NCH];
    logic        m_playing  [NCH];
    logic        m_backward [NCH];
    logic [15:0] m_addr     [NCH];
    logic [15:0] m_frac     [NCH];
    logic [15:0] m_step     [NCH];
    logic [15:0] m_step_fr  [NCH];
    logic [15:0] m_st_off   [NCH];
    logic [15:0] m_loop     [NCH];
    logic [15:0] m_end      [NCH];
    logic [5:0]  m_vol_l    [NCH];
    logic [5:0]  m_vol_r    [NCH];
    logic [7:0]  m_prev_l   [NCH];
    logic [7:0]  m_prev_r   [NCH];

    t_levels pending_levels[$];
    int errors = 0;
    int levels_seen = 0;
    int commands_sent = 0;
    int idle_cycles = 0;
    bit gaps_on = 0;
    bit stalls_on = 0;
    int long_hold_req = 0;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int fetch_sample(logic [15:0] a, logic flip);
        logic [7:0] b;
        b = sample_mem[a];
        if (flip) b ^= 8'h80;
        return int'($signed(b));
    endfunction

    function automatic logic [15:0] to_offset_binary(longint s);
        longint v;
        v = (s >= 0) ? (s >>> 6) : -((-s + 63) >>> 6);
        if (v < -32768) v = -32768;
        else if (v > 32767) v = 32767;
        return 16'(v + 32768);
    endfunction

    function automatic void advance_voice(int c, ref longint sum_l, ref longint sum_r);
        logic [1:0]  mode;
        int          s1, s2, f, sl, sr, back_addr;
        logic [16:0] fsum, fwd_addr;
        mode = m_ctl[c][4:3];
        s1 = fetch_sample(m_addr[c], m_ctl[c][smp_pkg::CTL_UNSIGNED]);
        s2 = s1;
        if (m_ctl[c][smp_pkg::CTL_STEREO])
            s2 = fetch_sample(m_addr[c] + m_st_off[c], m_ctl[c][smp_pkg::CTL_UNSIGNED]);
        f = int'(m_frac[c][15:8]);
        sl = int'($signed(m_prev_l[c])) * (256 - f) + s1 * f;
        sr = int'($signed(m_prev_r[c])) * (256 - f) + s2 * f;
        sum_l += longint'(sl) * longint'(m_vol_l[c]);
        sum_r += longint'(sr) * longint'(m_vol_r[c]);
        fsum = {1'b0, m_frac[c]} + {1'b0, m_step_fr[c]};
        m_frac[c] = fsum[15:0];
        if (fsum[16]) begin
            m_prev_l[c] = s1[7:0];
            m_prev_r[c] = s2[7:0];
            if (!m_backward[c]) begin
                fwd_addr = {1'b0, m_addr[c]} + {1'b0, m_step[c]};
                if (fwd_addr > {1'b0, m_end[c]}) begin
                    if (mode == smp_pkg::LOOP_FWD) begin
                        m_addr[c] = m_loop[c];
                    end else if (mode == smp_pkg::LOOP_BIDIR) begin
                        m_addr[c] = m_end[c];
                        m_backward[c] = 1;
                    end else begin
                        m_playing[c] = 0;
                    end
                end else begin
                    m_addr[c] = fwd_addr[15:0];
                end
            end else begin
                back_addr = int'(m_addr[c]) - int'(m_step[c]);
                if (back_addr < int'(m_loop[c])) begin
                    m_addr[c] = m_loop[c];
                    m_backward[c] = 0;
                end else begin
                    m_addr[c] = 16'(back_addr);
                end
            end
        end
    endfunction

    function automatic void predict_command(logic [1:0] cmd, logic [3:0] c, logic [3:0] sel,
                                            logic [15:0] a, logic [15:0] d);
        longint  sum_l, sum_r;
        int      n;
        t_levels lv;
        sum_l = 0;
        sum_r = 0;
        case (cmd)
            smp_pkg::CMD_SAMPLE: sample_mem[a] = d[7:0];
            smp_pkg::CMD_REG: begin
                case (sel)
                    smp_pkg::REG_CONTROL: m_ctl[c] = d[4:0];
                    smp_pkg::REG_START: begin
                        m_addr[c] = d;
                        m_frac[c] = '0;
                        m_prev_l[c] = '0;
                        m_prev_r[c] = '0;
                        m_playing[c] = 1;
                        m_backward[c] = 0;
                    end
                    smp_pkg::REG_STEP:    m_step[c] = d;
                    smp_pkg::REG_STEP_FR: m_step_fr[c] = d;
                    smp_pkg::REG_ST_OFF:  m_st_off[c] = d;
                    smp_pkg::REG_LOOP:    m_loop[c] = d;
                    smp_pkg::REG_END:     m_end[c] = d;
                    smp_pkg::REG_VOL_L:   m_vol_l[c] = d[5:0];
                    smp_pkg::REG_VOL_R:   m_vol_r[c] = d[5:0];
                    default: ;
                endcase
            end
            smp_pkg::CMD_TICK: begin
                n = (mix_count > NCH) ? NCH : int'(mix_count);
                for (int i = 0; i < n; i++)
                    if (m_ctl[i][smp_pkg::CTL_ACTIVE] && m_playing[i])
                        advance_voice(i, sum_l, sum_r);
                lv.left = to_offset_binary(sum_l);
                lv.right = to_offset_binary(sum_r);
                pending_levels.push_back(lv);
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predict_command(i_command, i_channel, i_reg_select, i_address, i_data);
                commands_sent++;
            end
            if (o_valid && !i_stall) begin
                levels_seen++;
                if (pending_levels.size() == 0) begin
                    $display("%0t: unexpected output beat left %h right %h",
                             $time, o_left_level, o_right_level);
                    errors++;
                end else begin
                    t_levels lv;
                    lv = pending_levels.pop_front();
                    if (o_left_level !== lv.left) begin
                        $display("%0t: left level expected %h actual %h",
                                 $time, lv.left, o_left_level);
                        errors++;
                    end
                    if (o_right_level !== lv.right) begin
                        $display("%0t: right level expected %h actual %h",
                                 $time, lv.right, o_right_level);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a beat.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("sample_playback_mixer regression: fail");
            $finish;
        end
    end

    // Receiver: random stalls, an occasional long one, and a requested long hold.
    initial begin
        int run;
        i_stall = 0;
        run = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req > 0) begin
                i_stall <= 1;
                long_hold_req <= long_hold_req - 1;
            end else if (run > 0) begin
                run--;
            end else if (!stalls_on) begin
                i_stall <= 0;
            end else if ($urandom_range(0, 49) == 0) begin
                i_stall <= 1;
                run = $urandom_range(20, 60);
            end else begin
                i_stall <= ($urandom_range(0, 2) == 0);
            end
        end
    end

    task automatic send_command(logic [1:0] cmd, logic [3:0] c, logic [3:0] sel,
                                logic [15:0] a, logic [15:0] d);
        int gap;
        i_valid <= 1;
        i_command <= cmd;
        i_channel <= c;
        i_reg_select <= sel;
        i_address <= a;
        i_data <= d;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        gap = 0;
        if (gaps_on) gap = ($urandom_range(0, 29) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic set_reg(int c, logic [3:0] sel, logic [15:0] d);
        send_command(smp_pkg::CMD_REG, 4'(c), sel, 16'($urandom), d);
    endtask

    task automatic wait_drained();
        i_valid <= 0;
        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_channel_count(logic [4:0] v);
        wait_drained();
        i_cfg_we <= 1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        mix_count = v;
    endtask

    // Playback only touches bytes 0..511 and 0xFF00..0xFFFF, so those are loaded first.
    task automatic test_load_samples();
        for (int a = 0; a < 512; a++)
            send_command(smp_pkg::CMD_SAMPLE, 0, 0, 16'(a), 16'($urandom));
        for (int a = 16'hFF00; a <= 16'hFFFF; a++)
            send_command(smp_pkg::CMD_SAMPLE, 0, 0, 16'(a), 16'($urandom));
    endtask

    task automatic test_idle_tick();
        send_command(smp_pkg::CMD_TICK, 0, 0, 0, 0);
        send_command(smp_pkg::CMD_TICK, 4'hF, 4'hF, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_directed();
        // Full-scale bytes at full volume on the signed (even) channels drive both sums into saturation.
        send_command(smp_pkg::CMD_SAMPLE, 0, 0, 16'h0010, 16'hFF7F);
        send_command(smp_pkg::CMD_SAMPLE, 0, 0, 16'h0011, 16'h0080);
        for (int c = 0; c < NCH; c++) begin
            set_reg(c, smp_pkg::REG_VOL_L, 16'hFFFF);
            set_reg(c, smp_pkg::REG_VOL_R, 16'h003F);
            set_reg(c, smp_pkg::REG_STEP_FR, 16'hFFFF);
            set_reg(c, smp_pkg::REG_END, 16'h0011);
            set_reg(c, smp_pkg::REG_STEP, 16'h0001);
            set_reg(c, smp_pkg::REG_CONTROL, {11'h0, smp_pkg::LOOP_BIDIR, 1'b1, c[0], 1'b1});
            set_reg(c, smp_pkg::REG_ST_OFF, 16'h0001);
            set_reg(c, smp_pkg::REG_START, 16'h0010);
        end
        repeat (6) send_command(smp_pkg::CMD_TICK, 0, 0, 0, 0);
        // Start at the top of memory: stereo read wraps and the end compare must not.
        set_reg(1, smp_pkg::REG_START, 16'hFFFF);
        set_reg(1, smp_pkg::REG_END, 16'hFFFF);
        set_reg(1, smp_pkg::REG_STEP, 16'h0002);
        set_reg(2, smp_pkg::REG_START, 16'hFFFF);
        set_reg(2, smp_pkg::REG_LOOP, 16'h0005);
        set_reg(2, smp_pkg::REG_CONTROL, {11'h0, smp_pkg::LOOP_FWD, 3'b101});
        set_reg(3, smp_pkg::REG_ST_OFF, 16'hFFFF);
        set_reg(3, smp_pkg::REG_CONTROL, {11'h0, 2'd3, 3'b111});
        set_reg(4, smp_pkg::REG_STEP, 16'hFFFF);
        set_reg(4, smp_pkg::REG_LOOP, 16'h0000);
        set_reg(5, smp_pkg::REG_CONTROL, {11'h0, smp_pkg::LOOP_NONE, 3'b011});
        repeat (6) send_command(smp_pkg::CMD_TICK, 0, 0, 0, 0);
        // Bring channel 1 back to the low bytes before it walks below the loaded top page.
        set_reg(1, smp_pkg::REG_END, 16'h0011);
        set_reg(1, smp_pkg::REG_START, 16'h0010);
        // Unused select codes and command code 3 change nothing.
        for (int s = 9; s < 16; s++) set_reg($urandom_range(0, 15), 4'(s), 16'($urandom));
        send_command(2'd3, 4'hF, 4'hF, 16'hFFFF, 16'hFFFF);
        send_command(smp_pkg::CMD_TICK, 0, 0, 0, 0);
    endtask

    function automatic logic [15:0] reg_value(logic [3:0] sel);
        if (sel == smp_pkg::REG_START || sel == smp_pkg::REG_LOOP || sel == smp_pkg::REG_END)
            return 16'($urandom_range(0, 255));
        if (sel == smp_pkg::REG_ST_OFF)
            return $urandom_range(0, 1) ? 16'($urandom_range(0, 255))
                                        : 16'($urandom_range(16'hFF00, 16'hFFFF));
        if (sel == smp_pkg::REG_STEP)
            return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
        return 16'($urandom);
    endfunction

    task automatic test_random(int n);
        int pick;
        logic [3:0] sel;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                send_command(smp_pkg::CMD_TICK, 4'($urandom), 4'($urandom), 16'($urandom),
                             16'($urandom));
            end else if (pick < 70) begin
                sel = 4'($urandom_range(0, 9) == 0 ? $urandom_range(9, 15)
                                                   : $urandom_range(0, 8));
                send_command(smp_pkg::CMD_REG, 4'($urandom), sel, 16'($urandom),
                             reg_value(sel));
            end else if (pick < 95) begin
                send_command(smp_pkg::CMD_SAMPLE, 4'($urandom), 4'($urandom), 16'($urandom),
                             16'($urandom));
            end else begin
                send_command(2'd3, 4'($urandom), 4'($urandom), 16'($urandom), 16'($urandom));
            end
        end
    endtask

    // The receiver holds for a long stretch while ticks keep coming, then the sender waits.
    task automatic test_backpressure();
        long_hold_req = 300;
        repeat (8) send_command(smp_pkg::CMD_TICK, 0, 0, 0, 0);
        wait_drained();
    endtask

    initial begin
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_data = '0;
        i_valid = 0;
        i_command = smp_pkg::CMD_SAMPLE;
        i_channel = '0;
        i_reg_select = '0;
        i_address = '0;
        i_data = '0;
        mix_count = smp_pkg::ACTIVE_RESET;
        for (int c = 0; c < NCH; c++) begin
            m_ctl[c] = '0; m_playing[c] = 0; m_backward[c] = 0; m_addr[c] = '0;
            m_frac[c] = '0; m_step[c] = '0; m_step_fr[c] = '0; m_st_off[c] = '0;
            m_loop[c] = '0; m_end[c] = '0; m_vol_l[c] = '0; m_vol_r[c] = '0;
            m_prev_l[c] = '0; m_prev_r[c] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        test_load_samples();
        test_idle_tick();
        write_channel_count(5'd16);
        test_directed();
        write_channel_count(5'd31);
        send_command(smp_pkg::CMD_TICK, 0, 0, 0, 0);
        write_channel_count(5'd0);
        send_command(smp_pkg::CMD_TICK, 0, 0, 0, 0);
        write_channel_count(5'd1);
        send_command(smp_pkg::CMD_TICK, 0, 0, 0, 0);
        write_channel_count(5'd16);
        test_random(100);
        gaps_on = 1;
        stalls_on = 1;
        test_random(150);
        test_backpressure();
        write_channel_count(5'($urandom_range(2, 15)));
        test_random(100);
        write_channel_count(5'd31);
        test_random(100);
        gaps_on = 0;
        stalls_on = 0;
        test_random(40);

        wait_drained();
        $display("Covered %0d commands and %0d mixed output beats across channel counts",
                 commands_sent, levels_seen);
        $display("0, 1, 16 and above 16, with loop modes, stereo wrap and backpressure.");
        if (errors == 0 && pending_levels.size() == 0) begin
            $display("sample_playback_mixer regression: pass");
        end else begin
            $display("sample_playback_mixer regression: fail");
        end
        $finish;
    end
endmodule
